/* rtl/core/lpbm_pkg.sv */
// Shared types and constants for the LRU page buffer manager.
`default_nettype none

package lpbm_pkg;

    localparam int MODE_W  = 3;
    localparam int PID_W   = 10;
    localparam int FR_W    = 6;
    localparam int SLOT_W  = 10;
    localparam int STAT_W  = 3;
    localparam int LIM_W   = 7;
    localparam int PDATA_W = 32;
    localparam int PADDR_W = 2;

    localparam logic [LIM_W-1:0]   LIMIT_RESET = 7'd64;
    localparam logic [PADDR_W-1:0] ADDR_LIMIT  = 2'd0;

    localparam logic [MODE_W-1:0] MODE_NEW     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_GET     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DIRTY   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RECYCLE = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STAT_W-1:0] STAT_NO_FRAME  = 3'd1;
    localparam logic [STAT_W-1:0] STAT_UNKNOWN   = 3'd2;
    localparam logic [STAT_W-1:0] STAT_EXHAUSTED = 3'd3;
    localparam logic [STAT_W-1:0] STAT_NOT_RES   = 3'd4;

    typedef enum logic [2:0] {
        OP_NEW,
        OP_GET,
        OP_RELEASE,
        OP_DIRTY,
        OP_RECYCLE,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [PID_W-1:0] page_id;
        logic             dirty_value;
    } req_t;

endpackage

`default_nettype wire

/* rtl/core/lpbm_front.sv */
// Front end: accepts request words, decodes the mode and queues them.
`default_nettype none

module lpbm_front
    import lpbm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [MODE_W-1:0] mode,
    input  wire logic [PID_W-1:0]  page_id,
    input  wire logic              dirty_value,
    input  wire logic              clearing,
    input  wire logic              q_pop,
    output logic                   busy,
    output logic                   q_valid,
    output req_t                   q_req
);

    req_t       e0_reg, e0_next, e1_reg, e1_next, new_req;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;

    always_comb
    begin
        new_req.page_id     = page_id;
        new_req.dirty_value = dirty_value;
        unique case (mode)
            MODE_NEW:     new_req.op = OP_NEW;
            MODE_GET:     new_req.op = OP_GET;
            MODE_RELEASE: new_req.op = OP_RELEASE;
            MODE_DIRTY:   new_req.op = OP_DIRTY;
            MODE_RECYCLE: new_req.op = OP_RECYCLE;
            default:      new_req.op = OP_NOP;
        endcase
    end

    assign busy    = (cnt_reg == 2'd2) || clearing;
    assign push    = start && !busy;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_req   = e0_reg;

    always_comb
    begin
        logic [1:0] c;
        e0_next = e0_reg;
        e1_next = e1_reg;
        c       = cnt_reg;
        if (q_pop && q_valid)
        begin
            e0_next = e1_reg;
            c       = cnt_reg - 2'd1;
        end
        if (push)
        begin
            if (c == 2'd0)
            begin
                e0_next = new_req;
            end
            else
            begin
                e1_next = new_req;
            end
        end
        cnt_next = c + {1'b0, push};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e0_reg <= e0_next;
        e1_reg <= e1_next;
    end

endmodule

`default_nettype wire

/* rtl/core/lpbm_back.sv */
// Back end: page table, recency list, frame stack, id FIFO and request sequencer.
`default_nettype none

module lpbm_back
    import lpbm_pkg::*;
#(
    parameter int FRAMES    = 64,
    parameter int MAX_PAGES = 1024
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [LIM_W-1:0]   limit,
    input  wire logic               q_valid,
    input  req_t                    q_req,
    output logic                    q_pop,
    output logic                    clearing,
    output logic                    done,
    output logic [STAT_W-1:0]       status,
    output logic [PID_W-1:0]        result_page,
    output logic [FR_W-1:0]         frame,
    output logic                    evict_valid,
    output logic [PID_W-1:0]        evict_page,
    output logic                    writeback_valid,
    output logic [SLOT_W-1:0]       writeback_slot,
    output logic                    load_valid,
    output logic [SLOT_W-1:0]       load_slot
);

    localparam int AW  = $clog2(MAX_PAGES);
    localparam int FRW = $clog2(FRAMES);
    localparam int CW  = $clog2(FRAMES + 1);
    localparam int NW  = AW + 1;
    localparam int TW  = AW + 2;
    localparam int XW  = (AW + 1 > PID_W) ? AW + 1 : PID_W + 1;
    localparam int FXW = (FRW > FR_W) ? FRW : FR_W;

    typedef struct packed {
        logic           resident;
        logic           pinned;
        logic           dirty;
        logic           has_slot;
        logic           free;
        logic [FRW-1:0] frame;
        logic [AW-1:0]  slot;
    } prec_t;

    typedef enum logic [1:0] {
        PUR_EVICT,
        PUR_TOUCH,
        PUR_RECY
    } purpose_t;

    typedef enum logic [16:0] {
        S_CLEAR    = 17'b00000000000000001,
        S_IDLE     = 17'b00000000000000010,
        S_CLASS    = 17'b00000000000000100,
        S_PCHK     = 17'b00000000000001000,
        S_TAKE     = 17'b00000000000010000,
        S_FS_RD    = 17'b00000000000100000,
        S_EV_RD    = 17'b00000000001000000,
        S_EV_ID    = 17'b00000000010000000,
        S_EV_CHK   = 17'b00000000100000000,
        S_FIND_RD  = 17'b00000001000000000,
        S_FIND_CHK = 17'b00000010000000000,
        S_SH_RD    = 17'b00000100000000000,
        S_SH_WR    = 17'b00001000000000000,
        S_GOT      = 17'b00010000000000000,
        S_ID_RD    = 17'b00100000000000000,
        S_ID_PRD   = 17'b01000000000000000,
        S_FINISH   = 17'b10000000000000000
    } state_t;

    // memories
    prec_t          pm_mem [MAX_PAGES];
    logic [AW-1:0]  lr_mem [FRAMES];
    logic [FRW-1:0] fs_mem [FRAMES];
    logic [AW-1:0]  ff_mem [MAX_PAGES];

    prec_t          pm_q, pm_wd;
    logic [AW-1:0]  pm_wa, pm_ra, lr_q, lr_wd, ff_q, ff_wd, ff_wa, ff_ra;
    logic [FRW-1:0] lr_wa, lr_ra, fs_q, fs_wd, fs_wa, fs_ra, fs_ra_q;
    logic           pm_we, lr_we, fs_we, ff_we;

    state_t            state_reg, state_next;
    op_t               op_reg, op_next;
    purpose_t          pur_reg, pur_next;
    logic [PID_W-1:0]  pid_reg, pid_next;
    logic              dv_reg, dv_next;
    prec_t             rec_reg, rec_next;
    logic [AW-1:0]     ev_reg, ev_next, id_reg, id_next;
    logic [CW-1:0]     i_reg, i_next, cnt_reg, cnt_next;
    logic [FRW-1:0]    fr_reg, fr_next;
    logic [AW-1:0]     clr_reg, clr_next, fhead_reg, fhead_next;
    logic [NW-1:0]     fcount_reg, fcount_next, nfresh_reg, nfresh_next;
    logic [NW-1:0]     nslot_reg, nslot_next;
    logic [FRAMES-1:0] fvalid_reg, fvalid_next;

    logic              done_reg, done_next;
    logic [STAT_W-1:0] st_reg, st_next;
    logic [PID_W-1:0]  page_reg, page_next;
    logic [FRW-1:0]    ofr_reg, ofr_next;
    logic              evv_reg, evv_next, wbv_reg, wbv_next, ldv_reg, ldv_next;
    logic [AW-1:0]     evp_reg, evp_next, wbs_reg, wbs_next, lds_reg, lds_next;

    logic [XW-1:0]  pgx, idx_w, evx, wbx, ldx;
    logic [FXW-1:0] frx;
    logic [AW-1:0]  pg;
    logic [FRW-1:0] fs_eff;

    assign pgx = XW'(pid_reg);
    assign pg  = pgx[AW-1:0];
    assign idx_w = XW'(id_reg);
    assign fs_eff = fvalid_reg[fs_ra_q] ? fs_q : FRW'(FRAMES - 1 - int'(fs_ra_q));

    always_ff @(posedge clk)
    begin
        if (pm_we)
        begin
            pm_mem[pm_wa] <= pm_wd;
        end
        pm_q <= pm_mem[pm_ra];
    end

    always_ff @(posedge clk)
    begin
        if (lr_we)
        begin
            lr_mem[lr_wa] <= lr_wd;
        end
        lr_q <= lr_mem[lr_ra];
    end

    always_ff @(posedge clk)
    begin
        if (fs_we)
        begin
            fs_mem[fs_wa] <= fs_wd;
        end
        fs_q    <= fs_mem[fs_ra];
        fs_ra_q <= fs_ra;
    end

    always_ff @(posedge clk)
    begin
        if (ff_we)
        begin
            ff_mem[ff_wa] <= ff_wd;
        end
        ff_q <= ff_mem[ff_ra];
    end

    always_comb
    begin
        int            lim_i;
        prec_t         v;
        logic [TW-1:0] tail;
        logic [CW-1:0] cdec;

        state_next  = state_reg;
        op_next     = op_reg;
        pur_next    = pur_reg;
        pid_next    = pid_reg;
        dv_next     = dv_reg;
        rec_next    = rec_reg;
        ev_next     = ev_reg;
        id_next     = id_reg;
        i_next      = i_reg;
        cnt_next    = cnt_reg;
        fr_next     = fr_reg;
        clr_next    = clr_reg;
        fhead_next  = fhead_reg;
        fcount_next = fcount_reg;
        nfresh_next = nfresh_reg;
        nslot_next  = nslot_reg;
        fvalid_next = fvalid_reg;
        done_next   = 1'b0;
        st_next     = st_reg;
        page_next   = page_reg;
        ofr_next    = ofr_reg;
        evv_next    = evv_reg;
        evp_next    = evp_reg;
        wbv_next    = wbv_reg;
        wbs_next    = wbs_reg;
        ldv_next    = ldv_reg;
        lds_next    = lds_reg;
        q_pop = 1'b0;
        pm_we = 1'b0; pm_wa = pg;     pm_wd = rec_reg; pm_ra = pg;
        lr_we = 1'b0; lr_wa = '0;     lr_wd = pg;      lr_ra = i_reg[FRW-1:0];
        fs_we = 1'b0; fs_wa = '0;     fs_wd = fr_reg;  fs_ra = '0;
        ff_we = 1'b0; ff_wa = '0;     ff_wd = pg;      ff_ra = fhead_reg;
        v     = pm_q;
        cdec  = cnt_reg - CW'(1);
        tail  = TW'(fhead_reg) + TW'(fcount_reg);
        if (tail >= TW'(MAX_PAGES))
        begin
            tail = tail - TW'(MAX_PAGES);
        end
        if (int'(limit) < 2)
        begin
            lim_i = 2;
        end
        else if (int'(limit) > FRAMES)
        begin
            lim_i = FRAMES;
        end
        else
        begin
            lim_i = int'(limit);
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                pm_we = 1'b1;
                pm_wa = clr_reg;
                pm_wd = '0;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(MAX_PAGES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    op_next    = q_req.op;
                    pid_next   = q_req.page_id;
                    dv_next    = q_req.dirty_value;
                    st_next    = STAT_OK;
                    page_next  = '0;
                    ofr_next   = '0;
                    evv_next   = 1'b0;
                    evp_next   = '0;
                    wbv_next   = 1'b0;
                    wbs_next   = '0;
                    ldv_next   = 1'b0;
                    lds_next   = '0;
                    state_next = S_CLASS;
                end
            end
            S_CLASS:
            begin
                if (op_reg == OP_NOP)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (op_reg == OP_NEW)
                begin
                    if (fcount_reg == '0 && nfresh_reg == NW'(MAX_PAGES))
                    begin
                        st_next    = STAT_EXHAUSTED;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_TAKE;
                    end
                end
                else
                begin
                    page_next = pid_reg;
                    if (pgx >= XW'(nfresh_reg))
                    begin
                        st_next    = STAT_UNKNOWN;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_PCHK;
                    end
                end
            end
            S_PCHK:
            begin
                rec_next = pm_q;
                i_next   = '0;
                if (pm_q.free)
                begin
                    st_next    = STAT_UNKNOWN;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    unique case (op_reg)
                        OP_GET:
                        begin
                            if (pm_q.resident)
                            begin
                                ofr_next   = pm_q.frame;
                                pur_next   = PUR_TOUCH;
                                state_next = S_FIND_RD;
                            end
                            else
                            begin
                                state_next = S_TAKE;
                            end
                        end
                        OP_RELEASE, OP_DIRTY:
                        begin
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                            if (!pm_q.resident)
                            begin
                                st_next = STAT_NOT_RES;
                            end
                            else
                            begin
                                if (op_reg == OP_RELEASE)
                                begin
                                    v.pinned = 1'b0;
                                end
                                else
                                begin
                                    v.dirty = dv_reg;
                                end
                                pm_we    = 1'b1;
                                pm_wd    = v;
                                ofr_next = pm_q.frame;
                            end
                        end
                        OP_RECYCLE:
                        begin
                            if (pm_q.resident)
                            begin
                                ofr_next   = pm_q.frame;
                                fr_next    = pm_q.frame;
                                pur_next   = PUR_RECY;
                                state_next = S_FIND_RD;
                            end
                            else
                            begin
                                state_next = S_FINISH;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_TAKE:
            begin
                i_next = '0;
                if (int'(cnt_reg) < lim_i)
                begin
                    fs_ra      = FRW'(FRAMES - 1 - int'(cnt_reg));
                    state_next = S_FS_RD;
                end
                else
                begin
                    state_next = S_EV_RD;
                end
            end
            S_FS_RD:
            begin
                fr_next    = fs_eff;
                state_next = S_GOT;
            end
            S_EV_RD:
            begin
                state_next = S_EV_ID;
            end
            S_EV_ID:
            begin
                ev_next    = lr_q;
                pm_ra      = lr_q;
                state_next = S_EV_CHK;
            end
            S_EV_CHK:
            begin
                if (!pm_q.pinned)
                begin
                    fr_next  = pm_q.frame;
                    evv_next = 1'b1;
                    evp_next = ev_reg;
                    if (pm_q.dirty)
                    begin
                        if (!pm_q.has_slot)
                        begin
                            v.has_slot = 1'b1;
                            v.slot     = nslot_reg[AW-1:0];
                            nslot_next = nslot_reg + NW'(1);
                        end
                        wbv_next = 1'b1;
                        wbs_next = v.slot;
                    end
                    v.resident = 1'b0;
                    v.dirty    = 1'b0;
                    pm_we      = 1'b1;
                    pm_wa      = ev_reg;
                    pm_wd      = v;
                    pur_next   = PUR_EVICT;
                    state_next = S_SH_RD;
                end
                else if (i_reg + CW'(1) == cnt_reg)
                begin
                    st_next    = STAT_NO_FRAME;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = S_EV_RD;
                end
            end
            S_FIND_RD:
            begin
                state_next = S_FIND_CHK;
            end
            S_FIND_CHK:
            begin
                if (lr_q == pg || i_reg + CW'(1) >= cnt_reg)
                begin
                    state_next = S_SH_RD;
                end
                else
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = S_FIND_RD;
                end
            end
            S_SH_RD:
            begin
                // close the gap at i: read entry i+1 here, write it to entry i in S_SH_WR
                if (i_reg + CW'(1) < cnt_reg)
                begin
                    lr_ra      = FRW'(i_reg + CW'(1));
                    state_next = S_SH_WR;
                end
                else
                begin
                    cnt_next = cdec;
                    unique case (pur_reg)
                        PUR_EVICT:
                        begin
                            state_next = S_GOT;
                        end
                        PUR_TOUCH:
                        begin
                            cnt_next   = cnt_reg;
                            lr_we      = 1'b1;
                            lr_wa      = cdec[FRW-1:0];
                            lr_wd      = pg;
                            v          = rec_reg;
                            v.pinned   = 1'b1;
                            pm_we      = 1'b1;
                            pm_wd      = v;
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                        default:
                        begin
                            fs_we = 1'b1;
                            fs_wa = FRW'(FRAMES - int'(cnt_reg));
                            fvalid_next[FRW'(FRAMES - int'(cnt_reg))] = 1'b1;
                            rec_next.resident = 1'b0;
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_SH_WR:
            begin
                lr_we      = 1'b1;
                lr_wa      = i_reg[FRW-1:0];
                lr_wd      = lr_q;
                i_next     = i_reg + CW'(1);
                state_next = S_SH_RD;
            end
            S_GOT:
            begin
                ofr_next = fr_reg;
                if (op_reg == OP_NEW)
                begin
                    if (fcount_reg != '0)
                    begin
                        state_next = S_ID_RD;
                    end
                    else
                    begin
                        id_next     = nfresh_reg[AW-1:0];
                        nfresh_next = nfresh_reg + NW'(1);
                        rec_next    = '0;
                        state_next  = S_FINISH;
                    end
                end
                else
                begin
                    v          = rec_reg;
                    v.resident = 1'b1;
                    v.pinned   = 1'b1;
                    v.frame    = fr_reg;
                    pm_we      = 1'b1;
                    pm_wd      = v;
                    lr_we      = 1'b1;
                    lr_wa      = cnt_reg[FRW-1:0];
                    cnt_next   = cnt_reg + CW'(1);
                    ldv_next   = rec_reg.has_slot;
                    lds_next   = rec_reg.has_slot ? rec_reg.slot : '0;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_ID_RD:
            begin
                id_next     = ff_q;
                pm_ra       = ff_q;
                fhead_next  = (fhead_reg == AW'(MAX_PAGES - 1)) ? '0 : fhead_reg + AW'(1);
                fcount_next = fcount_reg - NW'(1);
                state_next  = S_ID_PRD;
            end
            S_ID_PRD:
            begin
                rec_next   = pm_q;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                v          = rec_reg;
                if (op_reg == OP_NEW)
                begin
                    v.resident = 1'b1;
                    v.pinned   = 1'b1;
                    v.dirty    = 1'b0;
                    v.free     = 1'b0;
                    v.frame    = fr_reg;
                    pm_wa      = id_reg;
                    lr_we      = 1'b1;
                    lr_wa      = cnt_reg[FRW-1:0];
                    lr_wd      = id_reg;
                    cnt_next   = cnt_reg + CW'(1);
                    page_next  = idx_w[PID_W-1:0];
                end
                else
                begin
                    v.resident = 1'b0;
                    v.pinned   = 1'b0;
                    v.dirty    = 1'b0;
                    if (fcount_reg < NW'(MAX_PAGES))
                    begin
                        v.free      = 1'b1;
                        ff_we       = 1'b1;
                        ff_wa       = tail[AW-1:0];
                        fcount_next = fcount_reg + NW'(1);
                    end
                end
                pm_we = 1'b1;
                pm_wd = v;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            cnt_reg    <= '0;
            fhead_reg  <= '0;
            fcount_reg <= '0;
            nfresh_reg <= '0;
            nslot_reg  <= '0;
            fvalid_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            cnt_reg    <= cnt_next;
            fhead_reg  <= fhead_next;
            fcount_reg <= fcount_next;
            nfresh_reg <= nfresh_next;
            nslot_reg  <= nslot_next;
            fvalid_reg <= fvalid_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        pur_reg  <= pur_next;
        pid_reg  <= pid_next;
        dv_reg   <= dv_next;
        rec_reg  <= rec_next;
        ev_reg   <= ev_next;
        id_reg   <= id_next;
        i_reg    <= i_next;
        fr_reg   <= fr_next;
        st_reg   <= st_next;
        page_reg <= page_next;
        ofr_reg  <= ofr_next;
        evv_reg  <= evv_next;
        evp_reg  <= evp_next;
        wbv_reg  <= wbv_next;
        wbs_reg  <= wbs_next;
        ldv_reg  <= ldv_next;
        lds_reg  <= lds_next;
    end

    assign evx = XW'(evp_reg);
    assign wbx = XW'(wbs_reg);
    assign ldx = XW'(lds_reg);
    assign frx = FXW'(ofr_reg);

    assign clearing        = (state_reg == S_CLEAR);
    assign done            = done_reg;
    assign status          = st_reg;
    assign result_page     = page_reg;
    assign frame           = frx[FR_W-1:0];
    assign evict_valid     = evv_reg;
    assign evict_page      = evx[PID_W-1:0];
    assign writeback_valid = wbv_reg;
    assign writeback_slot  = wbx[SLOT_W-1:0];
    assign load_valid      = ldv_reg;
    assign load_slot       = ldx[SLOT_W-1:0];

endmodule

`default_nettype wire

/* rtl/core/lru_page_buffer_manager.sv */
// LRU page buffer manager with pinning: top level with the register port.
//
// Requests are taken on start while busy is low; a two-word queue lets the
// sequencer run while the next word arrives. Each word gives one result on the
// result ports, flagged by done for one cycle; the receiver cannot stall it.
// A get or a recycle of a resident page walks the recency list to find the
// page and then closes the gap. A request that must evict scans the list
// from the oldest entry, reading each entry and then its page record, and
// closes the gap in the same way. After reset the page table is cleared
// entry by entry, during which busy stays high.
`default_nettype none

module lru_page_buffer_manager
    import lpbm_pkg::*;
#(
    parameter int FRAMES    = 64,
    parameter int MAX_PAGES = 1024
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [PDATA_W-1:0]  pwdata,
    output logic      [PDATA_W-1:0]  prdata,
    output logic                     pready,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [MODE_W-1:0]   mode,
    input  wire logic [PID_W-1:0]    page_id,
    input  wire logic                dirty_value,
    output logic                     done,
    output logic      [STAT_W-1:0]   status,
    output logic      [PID_W-1:0]    result_page,
    output logic      [FR_W-1:0]     frame,
    output logic                     evict_valid,
    output logic      [PID_W-1:0]    evict_page,
    output logic                     writeback_valid,
    output logic      [SLOT_W-1:0]   writeback_slot,
    output logic                     load_valid,
    output logic      [SLOT_W-1:0]   load_slot
);

    logic [LIM_W-1:0] limit_reg, limit_next;
    logic             q_valid, q_pop, clearing;
    req_t             q_req;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_LIMIT) ? PDATA_W'(limit_reg) : '0;

    always_comb
    begin
        limit_next = limit_reg;
        if (psel && penable && pwrite && paddr == ADDR_LIMIT)
        begin
            limit_next = pwdata[LIM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    lpbm_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .mode        (mode),
        .page_id     (page_id),
        .dirty_value (dirty_value),
        .clearing    (clearing),
        .q_pop       (q_pop),
        .busy        (busy),
        .q_valid     (q_valid),
        .q_req       (q_req)
    );

    lpbm_back #(
        .FRAMES    (FRAMES),
        .MAX_PAGES (MAX_PAGES)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .limit           (limit_reg),
        .q_valid         (q_valid),
        .q_req           (q_req),
        .q_pop           (q_pop),
        .clearing        (clearing),
        .done            (done),
        .status          (status),
        .result_page     (result_page),
        .frame           (frame),
        .evict_valid     (evict_valid),
        .evict_page      (evict_page),
        .writeback_valid (writeback_valid),
        .writeback_slot  (writeback_slot),
        .load_valid      (load_valid),
        .load_slot       (load_slot)
    );

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    a_wb_needs_evict: assert property (@(posedge clk) disable iff (!rst_n)
        done && writeback_valid |-> evict_valid && status == STAT_OK)
        else $error("write-back without eviction");

    a_load_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && load_valid |-> status == STAT_OK)
        else $error("load request on failed word");

    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !q_pop && !done)
        else $error("activity during table clear");

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the LRU page buffer manager: predictor, driver and monitor.
`default_nettype none

module tb_top;
    import lpbm_pkg::*;

    localparam int NFR  = 64;
    localparam int NPG  = 1024;

    typedef struct packed {
        logic [MODE_W-1:0] md;
        logic [PID_W-1:0]  pid;
        logic              dv;
    } word_t;

    typedef struct packed {
        logic [STAT_W-1:0] st;
        logic [PID_W-1:0]  pg;
        logic [FR_W-1:0]   fr;
        logic              ev;
        logic [PID_W-1:0]  evp;
        logic              wb;
        logic [SLOT_W-1:0] wbs;
        logic              ld;
        logic [SLOT_W-1:0] lds;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;
    logic start = 1'b0;
    logic busy;
    logic [MODE_W-1:0] mode = '0;
    logic [PID_W-1:0] page_id = '0;
    logic dirty_value = 1'b0;
    logic done;
    logic [STAT_W-1:0] status;
    logic [PID_W-1:0] result_page, evict_page;
    logic [FR_W-1:0] frame;
    logic evict_valid, writeback_valid, load_valid;
    logic [SLOT_W-1:0] writeback_slot, load_slot;

    lru_page_buffer_manager dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    bit          p_res [NPG];
    bit [5:0]    p_frm [NPG];
    bit          p_pin [NPG];
    bit          p_dty [NPG];
    bit          p_hsl [NPG];
    bit [9:0]    p_slot [NPG];
    bit          p_free [NPG];
    int unsigned lru_q [$];
    int unsigned id_fifo [$];
    int unsigned fresh_id, slot_ctr;
    int unsigned frame_stk [NFR];
    int unsigned res_lim;

    word_t   pending [$];
    answer_t awaited [$];
    int      errors = 0;
    int      idle_pct = 0;
    bit      feeding = 1'b1;

    function automatic int take_frame(inout answer_t a);
        int unsigned lim, i, v;
        lim = res_lim < 2 ? 2 : (res_lim > NFR ? NFR : res_lim);
        if (lru_q.size() < lim)
            return int'(frame_stk[NFR - lru_q.size() - 1]);
        for (i = 0; i < lru_q.size(); i++)
            if (!p_pin[lru_q[i]]) break;
        if (i == lru_q.size()) return -1;
        v = lru_q[i];
        lru_q.delete(i);
        p_res[v] = 0;
        a.ev = 1; a.evp = PID_W'(v);
        if (p_dty[v])
        begin
            if (!p_hsl[v])
            begin
                p_hsl[v] = 1; p_slot[v] = 10'(slot_ctr); slot_ctr++;
            end
            a.wb = 1; a.wbs = p_slot[v];
        end
        p_dty[v] = 0;
        return int'(p_frm[v]);
    endfunction

    function automatic answer_t predict_answer(word_t w);
        answer_t a;
        int f, id, i;
        a = '0;
        if (w.md > MODE_RECYCLE) return a;
        if (w.md == MODE_NEW)
        begin
            if (id_fifo.size() == 0 && fresh_id >= NPG)
            begin
                a.st = STAT_EXHAUSTED; return a;
            end
            f = take_frame(a);
            if (f < 0)
            begin
                a.st = STAT_NO_FRAME; return a;
            end
            if (id_fifo.size() != 0)
            begin
                id = id_fifo.pop_front(); p_free[id] = 0;
            end
            else
            begin
                id = fresh_id++; p_hsl[id] = 0;
            end
            p_dty[id] = 0;
            p_frm[id] = FR_W'(f); p_res[id] = 1; p_pin[id] = 1; lru_q.push_back(id);
            a.pg = PID_W'(id); a.fr = FR_W'(f);
            return a;
        end
        a.pg = w.pid;
        if (w.pid >= fresh_id || p_free[w.pid])
        begin
            a.st = STAT_UNKNOWN; return a;
        end
        case (w.md)
            MODE_GET:
            begin
                if (p_res[w.pid])
                begin
                    for (i = 0; i < lru_q.size(); i++)
                        if (lru_q[i] == w.pid) begin lru_q.delete(i); break; end
                    lru_q.push_back(w.pid);
                    p_pin[w.pid] = 1; a.fr = p_frm[w.pid];
                    return a;
                end
                f = take_frame(a);
                if (f < 0)
                begin
                    a.st = STAT_NO_FRAME; return a;
                end
                p_frm[w.pid] = FR_W'(f); p_res[w.pid] = 1; p_pin[w.pid] = 1;
                lru_q.push_back(w.pid);
                a.fr = FR_W'(f);
                if (p_hsl[w.pid])
                begin
                    a.ld = 1; a.lds = p_slot[w.pid];
                end
            end
            MODE_RELEASE, MODE_DIRTY:
            begin
                if (!p_res[w.pid])
                begin
                    a.st = STAT_NOT_RES; return a;
                end
                if (w.md == MODE_RELEASE) p_pin[w.pid] = 0;
                else p_dty[w.pid] = w.dv;
                a.fr = p_frm[w.pid];
            end
            default:
            begin
                if (p_res[w.pid])
                begin
                    for (i = 0; i < lru_q.size(); i++)
                        if (lru_q[i] == w.pid) begin lru_q.delete(i); break; end
                    frame_stk[NFR - lru_q.size() - 1] = 32'(p_frm[w.pid]);
                    p_res[w.pid] = 0; a.fr = p_frm[w.pid];
                end
                p_pin[w.pid] = 0; p_dty[w.pid] = 0;
                id_fifo.push_back(w.pid); p_free[w.pid] = 1;
            end
        endcase
        return a;
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                awaited.push_back(predict_answer({mode, page_id, dirty_value}));
            if (!(start && busy) && feeding)
            begin
                if (pending.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    word_t w;
                    w = pending.pop_front();
                    start <= 1'b1; mode <= w.md; page_id <= w.pid; dirty_value <= w.dv;
                end
                else
                begin
                    start <= 1'b0;
                    mode <= 3'($urandom); page_id <= 10'($urandom);
                end
            end
            else if (!feeding && !busy)
                start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            answer_t got, exp;
            got = {status, result_page, frame, evict_valid, evict_page,
                   writeback_valid, writeback_slot, load_valid, load_slot};
            if (awaited.size() == 0)
            begin
                $display("%0t: unexpected word, actual %h", $time, got);
                errors++;
            end
            else
            begin
                exp = awaited.pop_front();
                if (got !== exp)
                begin
                    $display("%0t: mismatch expected %h actual %h", $time, exp, got);
                    errors++;
                end
            end
        end
    end

    task automatic write_limit(int unsigned v);
        @(posedge clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= ADDR_LIMIT; pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        res_lim = v & 7'h7F;
    endtask

    task automatic drain();
        while (pending.size() != 0 || awaited.size() != 0 || start)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    function automatic word_t rand_word();
        word_t w;
        int unsigned r, live;
        r = $urandom_range(99);
        live = fresh_id == 0 ? 1 : fresh_id;
        w.dv = 1'($urandom);
        if (r < 4) w.md = 3'($urandom_range(7, 5));
        else if (r < 22) w.md = MODE_NEW;
        else if (r < 50) w.md = MODE_GET;
        else if (r < 72) w.md = MODE_RELEASE;
        else if (r < 88) w.md = MODE_DIRTY;
        else w.md = MODE_RECYCLE;
        if ($urandom_range(19) == 0) w.pid = 10'($urandom);
        else w.pid = PID_W'($urandom_range(live + 1 > 1023 ? 1023 : live + 1));
        return w;
    endfunction

    task automatic run_phase(int n, int pct, int unsigned lim);
        write_limit(lim);
        idle_pct = pct;
        repeat (n) pending.push_back(rand_word());
        drain();
    endtask

    initial
    begin
        for (int k = 0; k < NPG; k++)
        begin
            p_res[k] = 0; p_pin[k] = 0; p_dty[k] = 0; p_hsl[k] = 0; p_free[k] = 0;
            p_frm[k] = 0; p_slot[k] = 0;
        end
        for (int k = 0; k < NFR; k++) frame_stk[k] = NFR - 1 - k;
        fresh_id = 0; slot_ctr = 0; res_lim = LIMIT_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        // directed: small scenario at the lowest limit
        write_limit(2);
        pending.push_back({MODE_GET, 10'd0, 1'b0});
        pending.push_back({MODE_NEW, 10'd0, 1'b0});
        pending.push_back({MODE_NEW, 10'd0, 1'b0});
        pending.push_back({MODE_NEW, 10'd0, 1'b0});
        pending.push_back({MODE_DIRTY, 10'd0, 1'b1});
        pending.push_back({MODE_RELEASE, 10'd0, 1'b0});
        pending.push_back({MODE_NEW, 10'd0, 1'b0});
        pending.push_back({MODE_RELEASE, 10'd1, 1'b0});
        pending.push_back({MODE_GET, 10'd0, 1'b0});
        pending.push_back({MODE_RELEASE, 10'd2, 1'b0});
        pending.push_back({MODE_DIRTY, 10'd2, 1'b1});
        pending.push_back({MODE_DIRTY, 10'd2, 1'b0});
        pending.push_back({MODE_RECYCLE, 10'd1, 1'b0});
        pending.push_back({MODE_RECYCLE, 10'd0, 1'b0});
        pending.push_back({MODE_GET, 10'd0, 1'b0});
        pending.push_back({MODE_NEW, 10'd0, 1'b0});
        pending.push_back({MODE_NEW, 10'd0, 1'b0});
        pending.push_back({MODE_RELEASE, 10'd1023, 1'b1});
        pending.push_back({3'd7, 10'd1023, 1'b1});
        pending.push_back({3'd5, 10'd0, 1'b0});
        drain();
        run_phase(150, 0, 64);
        run_phase(150, 78, 3);
        run_phase(150, 35, 127);
        run_phase(150, 0, 0);
        run_phase(150, 78, 8);
        // lower limit below resident count, then reuse of recycled ids
        run_phase(100, 35, 2);
        write_limit(64);
        idle_pct = 0;
        repeat (3) pending.push_back({MODE_NEW, 10'd0, 1'b0});
        pending.push_back({MODE_RECYCLE, 10'd5, 1'b0});
        pending.push_back({MODE_NEW, 10'd0, 1'b0});
        pending.push_back({MODE_NEW, 10'd0, 1'b0});
        drain();
        run_phase(100, 35, 16);
        feeding = 1'b0;
        if (errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin
        #40000000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
rtl/core/lpbm_pkg.sv
rtl/core/lpbm_front.sv
rtl/core/lpbm_back.sv
rtl/core/lru_page_buffer_manager.sv
tb/tb_top.sv
